>>> rtl/core/bca_pkg.sv
// Shared types and constants for the bitmap chunk allocator.
package bca_pkg;

  localparam int START_W  = 4;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FREED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOM   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request word
    logic read;    // pick the bitmap word and read it
    logic update;  // modify, write back, present the result
  } bca_cmd_t;

endpackage

>>> rtl/core/bca_ctrl.sv
// Controller state machine: sequences load, read and update of one request.
module bca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output bca_pkg::bca_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   accept;

  assign busy   = (state_r == S_READ);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = start ? S_READ : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_UPDATE);
    end
  end

  assign out_valid  = out_valid_r;
  assign cmd.load   = accept;
  assign cmd.read   = (state_r == S_READ);
  assign cmd.update = (state_r == S_UPDATE);

endmodule

>>> rtl/core/bca_datapath.sv
// Datapath: bitmap word memory, not-full summary, word search and bit update.
module bca_datapath #(
  parameter int NUM_CHUNKS = 1024,
  parameter int WORD_BITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bca_pkg::bca_cmd_t             cmd,
  input  logic                          in_req_type,
  input  logic [bca_pkg::START_W-1:0]   in_start_word,
  input  logic [bca_pkg::IDX_W-1:0]     in_free_index,
  output logic [bca_pkg::STATUS_W-1:0]  out_status,
  output logic [bca_pkg::IDX_W-1:0]     out_chunk_index
);

  localparam int NUM_WORDS = (NUM_CHUNKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LAST_BITS = NUM_CHUNKS - (NUM_WORDS - 1) * WORD_BITS;
  localparam int IDX_W     = bca_pkg::IDX_W;
  localparam int START_N   = 2 ** bca_pkg::START_W;
  // reciprocal for index / WORD_BITS, exact over the whole index range
  localparam int DIV_SH    = IDX_W + BW;
  localparam int MW        = DIV_SH + 1;
  localparam int DIV_M     = (2 ** DIV_SH + WORD_BITS - 1) / WORD_BITS;

  logic [WW-1:0]        start_lut [START_N];
  logic [WORD_BITS-1:0] last_pad;

  for (genvar i = 0; i < START_N; i++) begin : g_start
    assign start_lut[i] = WW'(i % NUM_WORDS);
  end
  for (genvar k = 0; k < WORD_BITS; k++) begin : g_pad
    assign last_pad[k] = (k >= LAST_BITS);
  end

  // request word
  logic              req_r;
  logic [WW-1:0]     start_r;
  logic [IDX_W-1:0]  fidx_r;
  logic [IDX_W-1:0]  fq_r;
  logic              frange_r;
  logic [IDX_W+MW-1:0] fprod;

  assign fprod = in_free_index * MW'(DIV_M);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req_type;
      start_r  <= start_lut[in_start_word];
      fidx_r   <= in_free_index;
      fq_r     <= IDX_W'(fprod >> DIV_SH);
      frange_r <= (32'(in_free_index) < 32'(NUM_CHUNKS));
    end
  end

  // storage and per-word flags
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] wvalid_r;
  logic [NUM_WORDS-1:0] full_r;

  // circular search for the first not-full word after start_r
  logic          hi_hit, lo_hit;
  logic [WW-1:0] hi_w, lo_w;

  always_comb begin
    hi_hit = 1'b0;
    lo_hit = 1'b0;
    hi_w   = '0;
    lo_w   = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        if (WW'(i) > start_r) begin
          hi_hit = 1'b1;
          hi_w   = WW'(i);
        end else begin
          lo_hit = 1'b1;
          lo_w   = WW'(i);
        end
      end
    end
  end

  logic          found;
  logic [WW-1:0] rd_addr;
  logic [31:0]   frem;

  assign found   = hi_hit || lo_hit;
  assign rd_addr = (req_r == bca_pkg::REQ_FREE) ? (frange_r ? fq_r[WW-1:0] : '0)
                                                : (hi_hit ? hi_w : lo_w);
  assign frem    = 32'(fidx_r) - 32'(fq_r) * 32'(WORD_BITS);

  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_valid_r;
  logic [WW-1:0]        word_r;
  logic                 found_r;
  logic [IDX_W-1:0]     base_r;
  logic [BW-1:0]        fbit_r;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= wvalid_r[rd_addr];
      word_r     <= rd_addr;
      found_r    <= found;
      base_r     <= IDX_W'(32'(rd_addr) * 32'(WORD_BITS));
      fbit_r     <= frem[BW-1:0];
    end
  end

  // read-modify-write of the selected word
  logic [WORD_BITS-1:0] cur, pad, eff, onehot, new_word;
  logic [BW-1:0]        zbit;
  logic                 wr_en;

  assign cur = rd_valid_r ? rd_data_r : '0;
  assign pad = (32'(word_r) == 32'(NUM_WORDS - 1)) ? last_pad : '0;
  assign eff = cur | pad;

  always_comb begin
    zbit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!eff[i]) zbit = BW'(i);
    end
  end

  assign onehot = WORD_BITS'(1) << zbit;

  always_comb begin
    if (req_r == bca_pkg::REQ_FREE) begin
      new_word = cur & ~(WORD_BITS'(1) << fbit_r);
      wr_en    = frange_r;
    end else begin
      new_word = cur | onehot;
      wr_en    = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) begin
      mem[word_r] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r <= '0;
      full_r   <= '0;
    end else if (cmd.update && wr_en) begin
      wvalid_r[word_r] <= 1'b1;
      full_r[word_r]   <= &(new_word | pad);
    end
  end

  logic [bca_pkg::STATUS_W-1:0] status_r;
  logic [IDX_W-1:0]             chunk_r;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (req_r == bca_pkg::REQ_FREE) begin
        status_r <= bca_pkg::ST_FREED;
        chunk_r  <= '0;
      end else if (found_r) begin
        status_r <= bca_pkg::ST_ALLOC;
        chunk_r  <= base_r + IDX_W'(zbit);
      end else begin
        status_r <= bca_pkg::ST_OOM;
        chunk_r  <= '0;
      end
    end
  end

  assign out_status      = status_r;
  assign out_chunk_index = chunk_r;

endmodule

>>> rtl/core/bitmap_chunk_allocator_top.sv
// Top level of the bitmap chunk allocator.
// Requests (allocate or free) are taken when start is high and busy is low.
// Each request does one read-modify-write of its bitmap word: the request is
// captured at the accept edge, the word is chosen (from the free index, or for
// an allocate from a per-word not-full summary) and read in the next cycle, and
// it is updated and written back in the cycle after. out_valid is high for one
// cycle, together with the registered result, and the receiver cannot stall it.
// busy is high for one cycle after each accept, so a new request can be taken while the last one is updated. Allocate
// scans from the word after start_word with wrap-around and takes the lowest
// free chunk; the summary makes that a single lookup. Every chunk is free
// right after reset, with no clearing pass: per-word valid bits stand in for
// the zeroed memory.
module bitmap_chunk_allocator_top #(
  parameter int NUM_CHUNKS = 1024,
  parameter int WORD_BITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [bca_pkg::START_W-1:0]   in_start_word,
  input  logic [bca_pkg::IDX_W-1:0]     in_free_index,
  output logic                          out_valid,
  output logic [bca_pkg::STATUS_W-1:0]  out_status,
  output logic [bca_pkg::IDX_W-1:0]     out_chunk_index
);

  bca_pkg::bca_cmd_t cmd;

  bca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bca_datapath #(
    .NUM_CHUNKS (NUM_CHUNKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_start_word   (in_start_word),
    .in_free_index   (in_free_index),
    .out_status      (out_status),
    .out_chunk_index (out_chunk_index)
  );

endmodule

>>> rtl/core/bca_checker.sv
// Port-level checks for the bitmap chunk allocator, bound to the top level.
module bca_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_req_type,
  input logic                          out_valid,
  input logic [bca_pkg::STATUS_W-1:0]  out_status,
  input logic [bca_pkg::IDX_W-1:0]     out_chunk_index
);

  // a result strobe follows every accepted request
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("no result three cycles after accept");

  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high two cycles in a row");

  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_free_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == bca_pkg::REQ_FREE |-> ##3
      (out_status == bca_pkg::ST_FREED && out_chunk_index == '0))
    else $error("free request did not report freed with zero index");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bca_pkg::ST_ALLOC |-> out_chunk_index == '0)
    else $error("nonzero chunk index without allocation");

endmodule

bind bitmap_chunk_allocator_top bca_checker u_bca_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_chunk_index (out_chunk_index)
);

>>> sim/testbench.sv
// Self-checking testbench for the bitmap chunk allocator: directed and random requests.
module testbench;

  localparam int NUM_CHUNKS = 1024;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = (NUM_CHUNKS + WORD_BITS - 1) / WORD_BITS;
  localparam int START_W    = bca_pkg::START_W;
  localparam int IDX_W      = bca_pkg::IDX_W;
  localparam int STATUS_W   = bca_pkg::STATUS_W;

  typedef struct packed {
    logic                req_type;
    logic [START_W-1:0]  start_word;
    logic [IDX_W-1:0]    free_index;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    chunk_index;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_req_type = 1'b0;
  logic [START_W-1:0]   in_start_word = '0;
  logic [IDX_W-1:0]     in_free_index = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [IDX_W-1:0]     out_chunk_index;

  request_t         pending_reqs[$];
  grant_t           expected_grants[$];
  logic [WORD_BITS-1:0] chunk_map [NUM_WORDS];

  int n_items = 0;
  int sent = 0;
  int errors = 0;
  int n_alloc = 0;
  int n_freed = 0;
  int n_oom = 0;

  bitmap_chunk_allocator_top #(
    .NUM_CHUNKS(NUM_CHUNKS),
    .WORD_BITS (WORD_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_start_word  (in_start_word),
    .in_free_index  (in_free_index),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_chunk_index(out_chunk_index)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Applies one request to the shadow chunk map and returns the grant it yields.
  function automatic grant_t allocate_or_free(input request_t rq);
    grant_t g;
    int     w;
    int     chunk;
    bit     found;
    g.status = bca_pkg::ST_FREED;
    g.chunk_index = '0;
    if (rq.req_type == bca_pkg::REQ_FREE) begin
      if (int'(rq.free_index) < NUM_CHUNKS)
        chunk_map[int'(rq.free_index) / WORD_BITS][int'(rq.free_index) % WORD_BITS] = 1'b0;
      return g;
    end
    found = 1'b0;
    for (int n = 1; n <= NUM_WORDS; n++) begin
      w = (int'(rq.start_word) + n) % NUM_WORDS;
      for (int k = 0; k < WORD_BITS; k++) begin
        chunk = w * WORD_BITS + k;
        if (!found && chunk < NUM_CHUNKS && !chunk_map[w][k]) begin
          chunk_map[w][k] = 1'b1;
          g.status = bca_pkg::ST_ALLOC;
          g.chunk_index = chunk[IDX_W-1:0];
          found = 1'b1;
        end
      end
    end
    if (!found) g.status = bca_pkg::ST_OOM;
    return g;
  endfunction

  task automatic queue_req(input logic rt, input logic [START_W-1:0] sw,
                           input logic [IDX_W-1:0] fi);
    request_t rq;
    rq.req_type = rt;
    rq.start_word = sw;
    rq.free_index = fi;
    pending_reqs.push_back(rq);
  endtask

  // Driver: one word per accept, sender gaps depend on how far the run is.
  always @(posedge clk) begin : drive
    request_t rq;
    int       gap_pct;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rq.req_type = in_req_type;
        rq.start_word = in_start_word;
        rq.free_index = in_free_index;
        expected_grants.push_back(allocate_or_free(rq));
      end
      if (!start || !busy) begin
        gap_pct = (sent < n_items / 3) ? 23 : (sent < 2 * n_items / 3) ? 63 : 0;
        if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
          rq = pending_reqs.pop_front();
          start <= 1'b1;
          in_req_type <= rq.req_type;
          in_start_word <= rq.start_word;
          in_free_index <= rq.free_index;
          sent <= sent + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin : monitor
    grant_t g;
    if (rst_n && out_valid) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result: status %0d chunk_index %0d", out_status, out_chunk_index);
        errors++;
      end else begin
        g = expected_grants.pop_front();
        if (out_status !== g.status) begin
          $error("status: expected %0d, actual %0d", g.status, out_status);
          errors++;
        end
        if (out_chunk_index !== g.chunk_index) begin
          $error("chunk_index: expected %0d, actual %0d", g.chunk_index, out_chunk_index);
          errors++;
        end
        case (g.status)
          bca_pkg::ST_ALLOC: n_alloc <= n_alloc + 1;
          bca_pkg::ST_FREED: n_freed <= n_freed + 1;
          default:           n_oom <= n_oom + 1;
        endcase
      end
    end
  end

  initial begin
    int allocs;
    for (int i = 0; i < NUM_WORDS; i++) chunk_map[i] = '0;

    // directed: wrap to word 0, start word visited last, frees of free chunks
    queue_req(bca_pkg::REQ_ALLOC, 4'd15, 10'd0);
    queue_req(bca_pkg::REQ_ALLOC, 4'd0,  10'd1023);
    queue_req(bca_pkg::REQ_ALLOC, 4'd14, 10'd0);
    queue_req(bca_pkg::REQ_ALLOC, 4'd15, 10'd1023);
    queue_req(bca_pkg::REQ_FREE,  4'd0,  10'd1023);
    queue_req(bca_pkg::REQ_FREE,  4'd15, 10'd0);
    queue_req(bca_pkg::REQ_FREE,  4'd15, 10'd0);
    queue_req(bca_pkg::REQ_ALLOC, 4'd15, 10'd0);
    queue_req(bca_pkg::REQ_FREE,  4'd7,  10'd64);
    queue_req(bca_pkg::REQ_ALLOC, 4'd7,  10'd512);
    queue_req(bca_pkg::REQ_ALLOC, 4'd0,  10'd0);
    queue_req(bca_pkg::REQ_FREE,  4'd0,  10'd960);
    queue_req(bca_pkg::REQ_ALLOC, 4'd14, 10'd1023);
    queue_req(bca_pkg::REQ_FREE,  4'd15, 10'd1);
    queue_req(bca_pkg::REQ_ALLOC, 4'd15, 10'd0);
    queue_req(bca_pkg::REQ_ALLOC, 4'd9,  10'd341);
    queue_req(bca_pkg::REQ_ALLOC, 4'd5,  10'd682);
    queue_req(bca_pkg::REQ_FREE,  4'd3,  10'd960);
    queue_req(bca_pkg::REQ_FREE,  4'd12, 10'd1023);

    // fill the map until it runs out, with the odd free mixed in
    allocs = 0;
    while (allocs < 1050) begin
      if ($urandom_range(39) == 0) begin
        queue_req(bca_pkg::REQ_FREE, START_W'($urandom_range(15)),
                  IDX_W'($urandom_range(1023)));
      end else begin
        queue_req(bca_pkg::REQ_ALLOC, START_W'($urandom_range(15)),
                  IDX_W'($urandom_range(1023)));
        allocs++;
      end
    end
    // churn on a nearly full map: freed holes get handed out again
    for (int i = 0; i < 30; i++)
      queue_req($urandom_range(1) ? bca_pkg::REQ_FREE : bca_pkg::REQ_ALLOC,
                START_W'($urandom_range(15)), IDX_W'($urandom_range(1023)));
    n_items = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_reqs.size() != 0 || start || expected_grants.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests: %0d allocations, %0d frees, %0d out of memory",
             n_items, n_alloc, n_freed, n_oom);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
